// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/rtdt_pkg.sv =====
// Types, codes and helpers for the RFID tag dedup table.
`timescale 1ns / 1ps

package rtdt_pkg;

  localparam int TABLE_DEPTH_DEF   = 32;
  localparam int EPC_MAX_BYTES_DEF = 12;
  localparam int SLOT_W            = 5;
  localparam int COUNT_W           = 6;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;
  localparam logic [2:0] ST_READ_OK  = 3'd5;
  localparam logic [2:0] ST_READ_OOR = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] epc_low;
    logic [31:0] epc_high;
    logic [3:0]  epc_length;
    logic [7:0]  signal_strength;
    logic [4:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  tag_count;
    logic [4:0]  slot;
    logic [63:0] out_epc_low;
    logic [31:0] out_epc_high;
    logic [3:0]  out_length;
    logic [7:0]  out_peak_rssi;
  } rsp_t;

  // Request as it walks the cell row; key fields carry the entry back on a read.
  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       lo;
    logic [31:0]       hi;
    logic [3:0]        len;
    logic [7:0]        rssi;
    logic [4:0]        ridx;
    logic              done;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
  } probe_t;

  function automatic logic [63:0] low_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [31:0] high_mask(input logic [3:0] len);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (4'(b + 8) < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== hdl/rtdt_cell.sv =====
// One table slot: stored entry plus the request register that passes it on.
`timescale 1ns / 1ps

module rtdt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    count,
  input  logic                probe_in_valid,
  input  rtdt_pkg::probe_t    probe_in,
  output logic                probe_out_valid,
  output rtdt_pkg::probe_t    probe_out
);

  logic [63:0] epc_low;
  logic [31:0] epc_high;
  logic [3:0]  length;
  logic [7:0]  peak_rssi;

  rtdt_pkg::probe_t probe_next;
  logic occupied, at_tail, match, ridx_hit, wr_entry, wr_rssi;

  assign occupied = CNT_W'(IDX) < count;
  assign at_tail  = CNT_W'(IDX) == count;
  assign match    = (length == probe_in.len) && (epc_low == probe_in.lo) &&
                    (epc_high == probe_in.hi);
  assign ridx_hit = (IDX < 32) && (32'(probe_in.ridx) == 32'(IDX));

  always_comb begin
    probe_next = probe_in;
    wr_entry   = 1'b0;
    wr_rssi    = 1'b0;
    if (!probe_in.done) begin
      if (probe_in.op == rtdt_pkg::OP_ADD) begin
        if (occupied && match) begin
          probe_next.done   = 1'b1;
          probe_next.status = rtdt_pkg::ST_UPDATED;
          probe_next.slot   = rtdt_pkg::SLOT_W'(IDX);
          if ($signed(probe_in.rssi) > $signed(peak_rssi)) begin
            wr_rssi = 1'b1;
          end else begin
            probe_next.rssi = peak_rssi;
          end
        end else if (at_tail) begin
          // first free slot and no earlier match: append here
          wr_entry          = 1'b1;
          probe_next.done   = 1'b1;
          probe_next.status = rtdt_pkg::ST_INSERTED;
          probe_next.slot   = rtdt_pkg::SLOT_W'(IDX);
        end
      end else if (probe_in.op == rtdt_pkg::OP_READ && occupied && ridx_hit) begin
        probe_next.done   = 1'b1;
        probe_next.status = rtdt_pkg::ST_READ_OK;
        probe_next.slot   = rtdt_pkg::SLOT_W'(IDX);
        probe_next.lo     = epc_low;
        probe_next.hi     = epc_high;
        probe_next.len    = length;
        probe_next.rssi   = peak_rssi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (probe_in_valid && wr_entry) begin
      epc_low  <= probe_in.lo;
      epc_high <= probe_in.hi;
      length   <= probe_in.len;
    end
    if (probe_in_valid && (wr_entry || wr_rssi)) begin
      peak_rssi <= probe_in.rssi;
    end
    probe_out <= probe_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out_valid <= 1'b0;
    end else begin
      probe_out_valid <= probe_in_valid;
    end
  end

endmodule

// ===== hdl/rfid_tag_dedup_table_core.sv =====
// RFID tag dedup table: top level with the cell row and the result register.
//
// Input channel in_valid/in_stall/in_data carries one request: add a tag
// (EPC of 1 to EPC_MAX_BYTES bytes with its RSSI), clear the set, or read a
// slot. Output channel out_valid/out_stall/out_data returns exactly one
// result per request with a status, the tag count after the request, the
// slot and, where it applies, the stored EPC and best RSSI.
// The table is a row of TABLE_DEPTH cells, one entry each. A request walks
// the row one cell per cycle; the matching cell updates its RSSI, the first
// free cell takes a new tag, the indexed cell hands its entry back.
// One request is in flight at a time: in_stall stays high until the result
// is taken, so a new request is accepted only once its walk through the
// cell row is over and the output has taken its result.
// A stalled result holds in the output register, and in_stall stays high.
// Reset empties the set at once (count to zero); stored entries are only
// reachable below the count, so no clearing pass is needed.
`timescale 1ns / 1ps

module rfid_tag_dedup_table_core #(
  parameter int TABLE_DEPTH   = rtdt_pkg::TABLE_DEPTH_DEF,
  parameter int EPC_MAX_BYTES = rtdt_pkg::EPC_MAX_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rtdt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rtdt_pkg::rsp_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_fire, out_fire, len_ok;

  rtdt_pkg::probe_t head;
  rtdt_pkg::probe_t chain [TABLE_DEPTH+1];
  logic             chain_valid [TABLE_DEPTH+1];
  rtdt_pkg::probe_t tail;
  rtdt_pkg::rsp_t   rsp_next;
  logic             tail_valid;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_fire = out_valid && !out_stall;
  assign len_ok   = (in_data.epc_length != 4'd0) &&
                    (in_data.epc_length <= 4'(EPC_MAX_BYTES));

  // Resolve requests that need no table walk before they enter the row.
  always_comb begin
    head.op     = in_data.opcode;
    head.lo     = in_data.epc_low & rtdt_pkg::low_mask(in_data.epc_length);
    head.hi     = in_data.epc_high & rtdt_pkg::high_mask(in_data.epc_length);
    head.len    = in_data.epc_length;
    head.rssi   = in_data.signal_strength;
    head.ridx   = in_data.read_index;
    head.done   = 1'b0;
    head.status = rtdt_pkg::ST_READ_OOR;
    head.slot   = '0;
    case (in_data.opcode)
      rtdt_pkg::OP_ADD: begin
        if (!len_ok) begin
          head.done   = 1'b1;
          head.status = rtdt_pkg::ST_BAD_LEN;
        end
      end
      rtdt_pkg::OP_CLEAR: begin
        head.done   = 1'b1;
        head.status = rtdt_pkg::ST_CLEARED;
      end
      rtdt_pkg::OP_READ: begin
      end
      default: begin
        head.done = 1'b1;
      end
    endcase
  end

  assign chain[0]       = head;
  assign chain_valid[0] = in_fire;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtdt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .count           (count),
      .probe_in_valid  (chain_valid[i]),
      .probe_in        (chain[i]),
      .probe_out_valid (chain_valid[i+1]),
      .probe_out       (chain[i+1])
    );
  end

  assign tail       = chain[TABLE_DEPTH];
  assign tail_valid = chain_valid[TABLE_DEPTH];

  always_comb begin
    logic [2:0] st;
    st = tail.status;
    if (!tail.done) begin
      st = (tail.op == rtdt_pkg::OP_ADD) ? rtdt_pkg::ST_FULL : rtdt_pkg::ST_READ_OOR;
    end
    count_next = count;
    if (st == rtdt_pkg::ST_INSERTED) begin
      count_next = count + CNT_W'(1);
    end else if (st == rtdt_pkg::ST_CLEARED) begin
      count_next = '0;
    end
    rsp_next.status        = st;
    rsp_next.tag_count     = rtdt_pkg::COUNT_W'(count_next);
    rsp_next.slot          = tail.slot;
    rsp_next.out_epc_low   = (st == rtdt_pkg::ST_READ_OK) ? tail.lo : 64'd0;
    rsp_next.out_epc_high  = (st == rtdt_pkg::ST_READ_OK) ? tail.hi : 32'd0;
    rsp_next.out_length    = (st == rtdt_pkg::ST_READ_OK) ? tail.len : 4'd0;
    rsp_next.out_peak_rssi = (st == rtdt_pkg::ST_READ_OK || st == rtdt_pkg::ST_INSERTED ||
                              st == rtdt_pkg::ST_UPDATED) ? tail.rssi : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (tail_valid) begin
      out_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        busy <= 1'b1;
      end else if (out_fire) begin
        busy <= 1'b0;
      end
      if (tail_valid) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/rtdt_checker.sv =====
// Port-level checks for the RFID tag dedup table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtdt_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rtdt_pkg::rsp_t out_data
);

  `ASSERT_PROP(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_PROP(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "request accepted while one in flight")
  `ASSERT_NEVER(a_no_accept_with_result, out_valid && !in_stall, "input open while a result waits")
  `ASSERT_NEVER(a_clear_count, out_valid && out_data.status == rtdt_pkg::ST_CLEARED && out_data.tag_count != 6'd0, "clear left tags")
  `ASSERT_NEVER(a_insert_slot, out_valid && out_data.status == rtdt_pkg::ST_INSERTED && out_data.slot != 5'(out_data.tag_count - 6'd1), "insert slot not at tail")

endmodule

bind rfid_tag_dedup_table_core rtdt_checker u_rtdt_checker (.*);
